// ----- hdl/kbs_pkg.sv -----
// Shared constants, register indexes and arctangent table for the bicycle step block.
package kbs_pkg;

    // Default sizes of the CORDIC unit
    localparam int KBS_ITER_DEF  = 16;
    localparam int KBS_ANGLE_DEF = 16;

    // Datapath widths
    localparam int KBS_CW   = 49;   // CORDIC x/y, holds the scaled vectoring input
    localparam int KBS_DVW  = 58;   // divider dividend magnitude
    localparam int KBS_CNTW = 6;    // iteration counter

    // Fixed constants
    localparam logic signed [15:0] KBS_STEER_LIMIT = 16'sd14563;
    localparam logic [27:0]        KBS_INV_GAIN    = 28'd163008219;  // 0.60725293, Q.28
    localparam logic [29:0]        KBS_RAD_TO_BA   = 30'd683565276;  // 65536/(2 pi), Q.16

    // Configuration register indexes
    localparam logic [2:0] REG_FRONT   = 3'd0;
    localparam logic [2:0] REG_REAR    = 3'd1;
    localparam logic [2:0] REG_DT      = 3'd2;
    localparam logic [2:0] REG_INIT_X  = 3'd3;
    localparam logic [2:0] REG_INIT_Y  = 3'd4;
    localparam logic [2:0] REG_INIT_V  = 3'd5;
    localparam logic [2:0] REG_INIT_HD = 3'd6;

    // Register reset values
    localparam logic [15:0] RST_FRONT = 16'd384;
    localparam logic [15:0] RST_REAR  = 16'd384;
    localparam logic [15:0] RST_DT    = 16'd6554;

    // atan(2^-i) with 2^32 per full turn
    function automatic logic [31:0] kbs_atan(input logic [4:0] i);
        logic [31:0] t;
        case (i)
            5'd0:  t = 32'h20000000;
            5'd1:  t = 32'h12E4051E;
            5'd2:  t = 32'h09FB385B;
            5'd3:  t = 32'h051111D4;
            5'd4:  t = 32'h028B0D43;
            5'd5:  t = 32'h0145D7E1;
            5'd6:  t = 32'h00A2F61E;
            5'd7:  t = 32'h00517C55;
            5'd8:  t = 32'h0028BE53;
            5'd9:  t = 32'h00145F2F;
            5'd10: t = 32'h000A2F98;
            5'd11: t = 32'h000517CC;
            5'd12: t = 32'h00028BE6;
            5'd13: t = 32'h000145F3;
            5'd14: t = 32'h0000A2FA;
            5'd15: t = 32'h0000517D;
            5'd16: t = 32'h000028BE;
            5'd17: t = 32'h0000145F;
            5'd18: t = 32'h00000A30;
            5'd19: t = 32'h00000518;
            5'd20: t = 32'h0000028C;
            5'd21: t = 32'h00000146;
            5'd22: t = 32'h000000A3;
            5'd23: t = 32'h00000051;
            default: t = 32'h00000000;
        endcase
        return t;
    endfunction

endpackage

// ----- hdl/kinematic_bicycle_step.sv -----
// Kinematic bicycle model, one time step per step beat, shared CORDIC/multiplier/divider.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-----------------------------------------------
//  in      | input     | in_valid/in_stall  | restart, acceleration, steer_angle
//  out     | output    | out_valid/out_stall| step_index, out_x, out_y, out_speed, out_heading
//  cfg     | input     | cfg_we             | cfg_index, cfg_data
//
// A restart beat leaves the sequencer idle. A step beat keeps the sequencer busy after
// accept for four CORDIC passes of one iteration a cycle, nine products through one
// 34x31 multiplier, and a 58-bit radix-2 divide for the heading rate. Zero rear distance
// skips the heading pass and divide; a zero steer vector skips vectoring.
// The result row (state before the step) is registered at accept; in_stall stays high
// while the sequencer runs or while that row is still held by out_stall.
// rst_n clears all state and restores register defaults; no clearing pass.
module kinematic_bicycle_step
    import kbs_pkg::*;
#(
    parameter int CORDIC_ITERATIONS = KBS_ITER_DEF,
    parameter int ANGLE_BITS        = KBS_ANGLE_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               restart,
    input  logic signed [15:0] acceleration,
    input  logic signed [15:0] steer_angle,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [31:0]        step_index,
    output logic signed [31:0] out_x,
    output logic signed [31:0] out_y,
    output logic signed [15:0] out_speed,
    output logic [15:0]        out_heading,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    localparam int AB = ANGLE_BITS;
    localparam int ZW = ANGLE_BITS + 2;
    localparam int CW = KBS_CW;
    localparam int DVW = KBS_DVW;
    localparam logic [KBS_CNTW-1:0] ITER_LAST = KBS_CNTW'(CORDIC_ITERATIONS - 1);
    localparam logic [KBS_CNTW-1:0] DIV_LAST  = KBS_CNTW'(DVW - 1);
    localparam logic signed [ZW-1:0] QUARTER = ZW'(1) <<< (AB - 2);
    localparam logic signed [ZW-1:0] HALF    = ZW'(1) <<< (AB - 1);

    // Sequencer states
    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_ROT_A   = 5'd1;
    localparam logic [4:0] S_M_CDL   = 5'd2;
    localparam logic [4:0] S_M_SDR   = 5'd3;
    localparam logic [4:0] S_VEC_ST  = 5'd4;
    localparam logic [4:0] S_VEC     = 5'd5;
    localparam logic [4:0] S_SLIP    = 5'd6;
    localparam logic [4:0] S_ROT_B   = 5'd7;
    localparam logic [4:0] S_M_VS    = 5'd8;
    localparam logic [4:0] S_M_WDT   = 5'd9;
    localparam logic [4:0] S_M_WK    = 5'd10;
    localparam logic [4:0] S_DIV_ST  = 5'd11;
    localparam logic [4:0] S_DIV     = 5'd12;
    localparam logic [4:0] S_DIV_END = 5'd13;
    localparam logic [4:0] S_ROT_C   = 5'd14;
    localparam logic [4:0] S_M_VDT   = 5'd15;
    localparam logic [4:0] S_M_DX    = 5'd16;
    localparam logic [4:0] S_M_DY    = 5'd17;
    localparam logic [4:0] S_M_ACC   = 5'd18;
    localparam logic [4:0] S_UPD     = 5'd19;

    // Configuration registers
    logic [15:0]        front_reg, rear_reg, dt_reg, init_v_reg, init_hd_reg;
    logic [31:0]        init_x_reg, init_y_reg;

    // Model state
    logic signed [31:0] cur_x_reg, cur_y_reg;
    logic signed [15:0] cur_v_reg;
    logic [15:0]        cur_hd_reg;
    logic [31:0]        tick_reg;

    // Output row
    logic               out_valid_reg;
    logic [31:0]        o_step_reg;
    logic signed [31:0] o_x_reg, o_y_reg;
    logic signed [15:0] o_v_reg;
    logic [15:0]        o_hd_reg;

    // Sequencer and datapath
    logic [4:0]           state_reg;
    logic [KBS_CNTW-1:0]  cnt_reg;
    logic signed [CW-1:0] cx_reg, cy_reg;
    logic signed [ZW-1:0] cz_reg, slip_reg;
    logic                 neg_reg;
    logic signed [30:0]   c_reg, s_reg;
    logic signed [64:0]   prod_reg, prod_next;
    logic signed [33:0]   vdt_reg;
    logic signed [28:0]   dx_reg, dy_reg;
    logic [15:0]          dh_reg;
    logic signed [15:0]   accel_reg;
    logic [DVW-1:0]       dvd_reg;
    logic [15:0]          rem_reg;
    logic                 dsign_reg;

    logic                 accept, iterating, up;
    logic [16:0]          len;
    logic signed [15:0]   steer_sat;
    logic [AB-1:0]        steer_int, hd_int, sum_ang, rot_ang;
    logic signed [ZW-1:0] rot_zs, rot_z, atan_z;
    logic                 rot_neg;
    logic [32:0]          atan_rnd;
    logic signed [CW-1:0] xs, ys;
    logic signed [30:0]   cos_val, sin_val;
    logic signed [33:0]   mul_a;
    logic signed [30:0]   mul_b;
    logic [16:0]          rem_sh;
    logic                 rem_ge;
    logic signed [DVW:0]  quo_s, dh_full;
    logic signed [32:0]   x_sum, y_sum;
    logic signed [17:0]   dv;
    logic signed [16:0]   v_sum;
    logic [31:0]          x_new, y_new;
    logic [15:0]          v_new;

    // 16-bit binary angle to internal angle
    function automatic logic [AB-1:0] to_int(input logic [15:0] a);
        logic [AB+15:0] w;
        w = {a, AB'(0)};
        return w[AB+15:16];
    endfunction

    assign accept    = in_valid && !in_stall;
    assign in_stall  = (state_reg != S_IDLE) || (out_valid_reg && out_stall);
    assign out_valid = out_valid_reg;
    assign step_index  = o_step_reg;
    assign out_x       = o_x_reg;
    assign out_y       = o_y_reg;
    assign out_speed   = o_v_reg;
    assign out_heading = o_hd_reg;

    assign len = {1'b0, front_reg} + {1'b0, rear_reg};

    // Steer saturation and angle conversions
    always_comb
    begin
        if (steer_angle > KBS_STEER_LIMIT)
            steer_sat = KBS_STEER_LIMIT;
        else if (steer_angle < -KBS_STEER_LIMIT)
            steer_sat = -KBS_STEER_LIMIT;
        else
            steer_sat = steer_angle;
        steer_int = to_int(steer_sat);
        hd_int    = to_int(cur_hd_reg);
        sum_ang   = hd_int + slip_reg[AB-1:0];
    end

    // Rotation start angle and quadrant fold
    always_comb
    begin
        case (state_reg)
            S_IDLE:  rot_ang = steer_int;
            S_SLIP:  rot_ang = (rear_reg != 16'd0) ? slip_reg[AB-1:0] : sum_ang;
            default: rot_ang = sum_ang;
        endcase
        rot_zs = ZW'($signed(rot_ang));
        if (rot_zs > QUARTER)
        begin
            rot_z   = rot_zs - HALF;
            rot_neg = 1'b1;
        end
        else if (rot_zs < -QUARTER)
        begin
            rot_z   = rot_zs + HALF;
            rot_neg = 1'b1;
        end
        else
        begin
            rot_z   = rot_zs;
            rot_neg = 1'b0;
        end
    end

    // CORDIC micro-rotation
    assign iterating = (state_reg == S_ROT_A) || (state_reg == S_ROT_B) ||
                       (state_reg == S_ROT_C) || (state_reg == S_VEC);
    assign atan_rnd  = {1'b0, kbs_atan(cnt_reg[4:0])} + (33'd1 << (31 - AB));
    assign atan_z    = $signed(ZW'(atan_rnd >> (32 - AB)));
    assign xs        = cx_reg >>> cnt_reg;
    assign ys        = cy_reg >>> cnt_reg;
    assign up        = (state_reg == S_VEC) ? !(cy_reg > 0) : !cz_reg[ZW-1];
    assign cos_val   = neg_reg ? -$signed(cx_reg[30:0]) : $signed(cx_reg[30:0]);
    assign sin_val   = neg_reg ? -$signed(cy_reg[30:0]) : $signed(cy_reg[30:0]);

    // Shared multiplier operand select
    always_comb
    begin
        case (state_reg)
            S_M_CDL:
            begin
                mul_a = 34'(cos_val);
                mul_b = 31'($signed({1'b0, len}));
            end
            S_M_SDR:
            begin
                mul_a = 34'(s_reg);
                mul_b = 31'($signed({1'b0, rear_reg}));
            end
            S_M_VS:
            begin
                mul_a = 34'(cur_v_reg);
                mul_b = sin_val;
            end
            S_M_WDT:
            begin
                mul_a = prod_reg[49:16];
                mul_b = 31'($signed({1'b0, dt_reg}));
            end
            S_M_WK:
            begin
                mul_a = prod_reg[49:16];
                mul_b = 31'($signed({1'b0, KBS_RAD_TO_BA}));
            end
            S_M_VDT:
            begin
                mul_a = 34'(cur_v_reg);
                mul_b = 31'($signed({1'b0, dt_reg}));
            end
            S_M_DX:
            begin
                mul_a = prod_reg[33:0];
                mul_b = c_reg;
            end
            S_M_DY:
            begin
                mul_a = vdt_reg;
                mul_b = s_reg;
            end
            S_M_ACC:
            begin
                mul_a = 34'(accel_reg);
                mul_b = 31'($signed({1'b0, dt_reg}));
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        prod_next = 65'(mul_a) * 65'(mul_b);
    end

    // Divider step and heading increment
    assign rem_sh  = {rem_reg, dvd_reg[DVW-1]};
    assign rem_ge  = rem_sh >= {1'b0, rear_reg};
    assign quo_s   = dsign_reg ? -$signed({1'b0, dvd_reg}) : $signed({1'b0, dvd_reg});
    assign dh_full = quo_s + (DVW+1)'(64'sd1 <<< 27);

    // State update with saturation
    always_comb
    begin
        x_sum = 33'(cur_x_reg) + 33'(dx_reg);
        y_sum = 33'(cur_y_reg) + 33'(dy_reg);
        dv    = 18'((prod_reg + 65'sd32768) >>> 16);
        v_sum = 17'(cur_v_reg) + 17'(dv);
        if (x_sum[32] != x_sum[31])
            x_new = x_sum[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        else
            x_new = x_sum[31:0];
        if (y_sum[32] != y_sum[31])
            y_new = y_sum[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        else
            y_new = y_sum[31:0];
        if (v_sum[16] != v_sum[15])
            v_new = v_sum[16] ? 16'h8000 : 16'h7FFF;
        else
            v_new = v_sum[15:0];
    end

    // Configuration, state, sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg     <= RST_FRONT;
            rear_reg      <= RST_REAR;
            dt_reg        <= RST_DT;
            init_x_reg    <= '0;
            init_y_reg    <= '0;
            init_v_reg    <= '0;
            init_hd_reg   <= '0;
            cur_x_reg     <= '0;
            cur_y_reg     <= '0;
            cur_v_reg     <= '0;
            cur_hd_reg    <= '0;
            tick_reg      <= '0;
            out_valid_reg <= 1'b0;
            o_step_reg    <= '0;
            o_x_reg       <= '0;
            o_y_reg       <= '0;
            o_v_reg       <= '0;
            o_hd_reg      <= '0;
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            cx_reg        <= '0;
            cy_reg        <= '0;
            cz_reg        <= '0;
            slip_reg      <= '0;
            neg_reg       <= 1'b0;
            c_reg         <= '0;
            s_reg         <= '0;
            prod_reg      <= '0;
            vdt_reg       <= '0;
            dx_reg        <= '0;
            dy_reg        <= '0;
            dh_reg        <= '0;
            accel_reg     <= '0;
            dvd_reg       <= '0;
            rem_reg       <= '0;
            dsign_reg     <= 1'b0;
        end
        else
        begin
            // register writes
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_FRONT:   front_reg   <= cfg_data[15:0];
                    REG_REAR:    rear_reg    <= cfg_data[15:0];
                    REG_DT:      dt_reg      <= cfg_data[15:0];
                    REG_INIT_X:  init_x_reg  <= cfg_data;
                    REG_INIT_Y:  init_y_reg  <= cfg_data;
                    REG_INIT_V:  init_v_reg  <= cfg_data[15:0];
                    REG_INIT_HD: init_hd_reg <= cfg_data[15:0];
                    default: ;
                endcase
            end

            // output row
            if (accept)
            begin
                out_valid_reg <= 1'b1;
                if (restart)
                begin
                    o_step_reg <= '0;
                    o_x_reg    <= init_x_reg;
                    o_y_reg    <= init_y_reg;
                    o_v_reg    <= init_v_reg;
                    o_hd_reg   <= init_hd_reg;
                end
                else
                begin
                    o_step_reg <= tick_reg;
                    o_x_reg    <= cur_x_reg;
                    o_y_reg    <= cur_y_reg;
                    o_v_reg    <= cur_v_reg;
                    o_hd_reg   <= cur_hd_reg;
                end
            end
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;

            // shared CORDIC iteration
            if (iterating)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (up)
                begin
                    cx_reg <= cx_reg - ys;
                    cy_reg <= cy_reg + xs;
                    cz_reg <= cz_reg - atan_z;
                end
                else
                begin
                    cx_reg <= cx_reg + ys;
                    cy_reg <= cy_reg - xs;
                    cz_reg <= cz_reg + atan_z;
                end
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        if (restart)
                        begin
                            cur_x_reg  <= init_x_reg;
                            cur_y_reg  <= init_y_reg;
                            cur_v_reg  <= init_v_reg;
                            cur_hd_reg <= init_hd_reg;
                            tick_reg   <= '0;
                        end
                        else
                        begin
                            accel_reg <= acceleration;
                            cx_reg    <= CW'(KBS_INV_GAIN);
                            cy_reg    <= '0;
                            cz_reg    <= rot_z;
                            neg_reg   <= rot_neg;
                            cnt_reg   <= '0;
                            state_reg <= S_ROT_A;
                        end
                    end
                end
                S_ROT_A:
                    if (cnt_reg == ITER_LAST)
                        state_reg <= S_M_CDL;
                S_M_CDL:
                begin
                    c_reg     <= cos_val;
                    s_reg     <= sin_val;
                    prod_reg  <= prod_next;
                    state_reg <= S_M_SDR;
                end
                S_M_SDR:
                begin
                    cx_reg    <= prod_reg[CW-1:0];
                    prod_reg  <= prod_next;
                    state_reg <= S_VEC_ST;
                end
                S_VEC_ST:
                begin
                    cy_reg  <= prod_reg[CW-1:0];
                    cz_reg  <= '0;
                    cnt_reg <= '0;
                    if (cx_reg == '0 && prod_reg == '0)
                    begin
                        slip_reg  <= '0;
                        state_reg <= S_SLIP;
                    end
                    else
                        state_reg <= S_VEC;
                end
                S_VEC:
                    if (cnt_reg == ITER_LAST)
                    begin
                        slip_reg  <= up ? cz_reg - atan_z : cz_reg + atan_z;
                        state_reg <= S_SLIP;
                    end
                S_SLIP:
                begin
                    cx_reg  <= CW'(KBS_INV_GAIN);
                    cy_reg  <= '0;
                    cz_reg  <= rot_z;
                    neg_reg <= rot_neg;
                    cnt_reg <= '0;
                    if (rear_reg != 16'd0)
                        state_reg <= S_ROT_B;
                    else
                    begin
                        dh_reg    <= '0;
                        state_reg <= S_ROT_C;
                    end
                end
                S_ROT_B:
                    if (cnt_reg == ITER_LAST)
                        state_reg <= S_M_VS;
                S_M_VS:
                begin
                    prod_reg  <= prod_next;
                    state_reg <= S_M_WDT;
                end
                S_M_WDT:
                begin
                    prod_reg  <= prod_next;
                    state_reg <= S_M_WK;
                end
                S_M_WK:
                begin
                    prod_reg  <= prod_next;
                    state_reg <= S_DIV_ST;
                end
                S_DIV_ST:
                begin
                    dsign_reg <= prod_reg[64];
                    dvd_reg   <= prod_reg[64] ? DVW'(-prod_reg) : prod_reg[DVW-1:0];
                    rem_reg   <= '0;
                    cnt_reg   <= '0;
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    rem_reg <= rem_ge ? 16'(rem_sh - {1'b0, rear_reg}) : rem_sh[15:0];
                    dvd_reg <= {dvd_reg[DVW-2:0], rem_ge};
                    if (cnt_reg == DIV_LAST)
                        state_reg <= S_DIV_END;
                end
                S_DIV_END:
                begin
                    dh_reg    <= dh_full[43:28];
                    cx_reg    <= CW'(KBS_INV_GAIN);
                    cy_reg    <= '0;
                    cz_reg    <= rot_z;
                    neg_reg   <= rot_neg;
                    cnt_reg   <= '0;
                    state_reg <= S_ROT_C;
                end
                S_ROT_C:
                    if (cnt_reg == ITER_LAST)
                        state_reg <= S_M_VDT;
                S_M_VDT:
                begin
                    c_reg     <= cos_val;
                    s_reg     <= sin_val;
                    prod_reg  <= prod_next;
                    state_reg <= S_M_DX;
                end
                S_M_DX:
                begin
                    vdt_reg   <= prod_reg[33:0];
                    prod_reg  <= prod_next;
                    state_reg <= S_M_DY;
                end
                S_M_DY:
                begin
                    dx_reg    <= 29'((prod_reg + (65'sd1 <<< 35)) >>> 36);
                    prod_reg  <= prod_next;
                    state_reg <= S_M_ACC;
                end
                S_M_ACC:
                begin
                    dy_reg    <= 29'((prod_reg + (65'sd1 <<< 35)) >>> 36);
                    prod_reg  <= prod_next;
                    state_reg <= S_UPD;
                end
                S_UPD:
                begin
                    cur_x_reg  <= x_new;
                    cur_y_reg  <= y_new;
                    cur_v_reg  <= v_new;
                    cur_hd_reg <= cur_hd_reg + dh_reg;
                    if (tick_reg != 32'hFFFF_FFFF)
                        tick_reg <= tick_reg + 1'b1;
                    state_reg  <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    // every accepted beat leaves a row on the output
    a_row_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid)
        else $error("no output row after accepted beat");

    // no beat taken while the sequencer runs
    a_busy_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> in_stall)
        else $error("input open while busy");

    // a step beat starts the steer rotation
    a_step_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !restart) |=> (state_reg == S_ROT_A && cnt_reg == '0))
        else $error("step beat did not start sequencer");

    // CORDIC counter stays inside the iteration count
    a_iter_bound: assert property (@(posedge clk) disable iff (!rst_n)
        iterating |-> (cnt_reg <= ITER_LAST))
        else $error("CORDIC counter out of range");

    // step count only changes at the update step or a restart
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_UPD && !(accept && restart)) |=> $stable(tick_reg))
        else $error("tick count changed outside update");
`endif

endmodule

// ----- tb/kinematic_bicycle_step_test.sv -----
// Self-checking testbench for the kinematic bicycle step block.
`timescale 1ns / 100ps

module kinematic_bicycle_step_test;
    import kbs_pkg::*;

    localparam int ITERS      = KBS_ITER_DEF;
    localparam int ABITS      = KBS_ANGLE_DEF;
    localparam longint AFULL  = longint'(1) <<< ABITS;
    localparam longint AMASK  = AFULL - 1;
    localparam int SETTLE_CYC = 4 * ITERS + 71 + 60;
    localparam int PHASES     = 10;
    localparam int PHASE_BEATS = 105;
    localparam int PLAN_ROWS  = 15;

    typedef struct {
        logic [31:0]        idx;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [15:0] v;
        logic [15:0]        hd;
    } row_t;

    typedef struct {
        bit                 rs;
        logic signed [15:0] acc;
        logic signed [15:0] st;
        bit                 typed;
        row_t               row;
    } stim_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic               restart;
    logic signed [15:0] acceleration;
    logic signed [15:0] steer_angle;
    logic               out_valid;
    logic               out_stall;
    logic [31:0]        step_index;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [15:0] out_speed;
    logic [15:0]        out_heading;
    logic               cfg_we;
    logic [2:0]         cfg_index;
    logic [31:0]        cfg_data;

    kinematic_bicycle_step i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .restart      (restart),
        .acceleration (acceleration),
        .steer_angle  (steer_angle),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .step_index   (step_index),
        .out_x        (out_x),
        .out_y        (out_y),
        .out_speed    (out_speed),
        .out_heading  (out_heading),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // Register mirror and vehicle state of the predictor
    logic [15:0]        cfg_front, cfg_rear, cfg_dt, cfg_v0, cfg_hd0;
    logic [31:0]        cfg_x0, cfg_y0;
    logic signed [31:0] veh_x, veh_y;
    logic signed [15:0] veh_v;
    logic [15:0]        veh_hd;
    logic [31:0]        veh_ticks;

    row_t pending_rows[$];
    int   n_fail;
    int   n_beats;
    int   n_rows;
    int   n_restarts;
    int   burst_left;
    int   gap_max;
    int   stall_pct;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run limit
    initial
    begin
        #20ms;
        $display("[kinematic_bicycle_step] ERROR");
        $finish;
    end

    // Receiver stall pattern
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    function automatic longint atan_step(input int i);
        return (longint'(kbs_atan(5'(i))) + (longint'(1) <<< (31 - ABITS))) >>> (32 - ABITS);
    endfunction

    // CORDIC rotation, cos and sin in Q.28
    function automatic void cordic_cs(input longint ang, output longint c, output longint s);
        longint z, x, y, xs, ys;
        bit     flip;
        z = ang & AMASK;
        x = longint'(KBS_INV_GAIN);
        y = 0;
        flip = 1'b0;
        if (z >= AFULL / 2)
            z = z - AFULL;
        if (z > AFULL / 4)
        begin
            z = z - AFULL / 2;
            flip = 1'b1;
        end
        else if (z < -(AFULL / 4))
        begin
            z = z + AFULL / 2;
            flip = 1'b1;
        end
        for (int i = 0; i < ITERS; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0)
            begin
                x = x - ys; y = y + xs; z = z - atan_step(i);
            end
            else
            begin
                x = x + ys; y = y - xs; z = z + atan_step(i);
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    // CORDIC vectoring, angle of (x, y)
    function automatic longint cordic_atan(input longint xi, input longint yi);
        longint x, y, z, xs, ys;
        x = xi;
        y = yi;
        z = 0;
        if (x == 0 && y == 0)
            return 0;
        for (int i = 0; i < ITERS; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0)
            begin
                x = x + ys; y = y - xs; z = z + atan_step(i);
            end
            else
            begin
                x = x - ys; y = y + xs; z = z - atan_step(i);
            end
        end
        return z;
    endfunction

    function automatic longint clip(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // Emits the row before the step, then advances the vehicle state
    task automatic advance_vehicle(input bit rs, input logic signed [15:0] acc,
                                   input logic signed [15:0] st, output row_t row);
        longint dt, v, r, len, steer, cd, sd, slip, cs, ss, c, s, w, dh, dx, dy;
        dt = longint'(cfg_dt);
        r = longint'(cfg_rear);
        len = longint'(cfg_front) + longint'(cfg_rear);
        if (rs)
        begin
            veh_x = cfg_x0;
            veh_y = cfg_y0;
            veh_v = cfg_v0;
            veh_hd = cfg_hd0;
            veh_ticks = '0;
        end
        v = longint'(veh_v);
        row.idx = veh_ticks;
        row.x = veh_x;
        row.y = veh_y;
        row.v = veh_v;
        row.hd = veh_hd;
        if (!rs)
        begin
            steer = clip(longint'(st), -longint'(KBS_STEER_LIMIT), longint'(KBS_STEER_LIMIT));
            cordic_cs(steer & 64'hFFFF, cd, sd);
            slip = cordic_atan(cd * len, sd * r);
            dh = 0;
            if (r != 0)
            begin
                cordic_cs(slip & AMASK, cs, ss);
                w = (v * ss) >>> 16;
                w = (w * dt) >>> 16;
                dh = ((w * longint'(KBS_RAD_TO_BA)) / r + (longint'(1) <<< 27)) >>> 28;
            end
            cordic_cs((longint'(veh_hd) + slip) & AMASK, c, s);
            dx = (v * c * dt + (longint'(1) <<< 35)) >>> 36;
            dy = (v * s * dt + (longint'(1) <<< 35)) >>> 36;
            veh_x = 32'(clip(longint'(veh_x) + dx, -(longint'(1) <<< 31), (longint'(1) <<< 31) - 1));
            veh_y = 32'(clip(longint'(veh_y) + dy, -(longint'(1) <<< 31), (longint'(1) <<< 31) - 1));
            veh_hd = 16'(longint'(veh_hd) + dh);
            veh_v = 16'(clip(v + ((longint'(acc) * dt + (longint'(1) <<< 15)) >>> 16),
                             -32768, 32767));
            if (veh_ticks != 32'hFFFF_FFFF)
                veh_ticks = veh_ticks + 1;
        end
    endtask

    // Result checker
    always @(posedge clk)
    begin
        row_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            n_rows++;
            if (pending_rows.size() == 0)
            begin
                $error("result row with nothing expected");
                n_fail++;
            end
            else
            begin
                want = pending_rows.pop_front();
                if (step_index !== want.idx)
                begin
                    $error("step_index exp %0d got %0d", want.idx, step_index);
                    n_fail++;
                end
                if (out_x !== want.x)
                begin
                    $error("out_x exp %0d got %0d", want.x, out_x);
                    n_fail++;
                end
                if (out_y !== want.y)
                begin
                    $error("out_y exp %0d got %0d", want.y, out_y);
                    n_fail++;
                end
                if (out_speed !== want.v)
                begin
                    $error("out_speed exp %0d got %0d", want.v, out_speed);
                    n_fail++;
                end
                if (out_heading !== want.hd)
                begin
                    $error("out_heading exp %0d got %0d", want.hd, out_heading);
                    n_fail++;
                end
            end
        end
    end

    // One input beat with bursty sender behavior; typed rows override the prediction
    task automatic send_beat(input stim_t sb);
        row_t row;
        int   gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(gap_max);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        in_valid <= 1'b1;
        restart <= sb.rs;
        acceleration <= sb.acc;
        steer_angle <= sb.st;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        advance_vehicle(sb.rs, sb.acc, sb.st, row);
        if (sb.typed)
            row = sb.row;
        pending_rows.insert(pending_rows.size(), row);
        n_beats++;
        if (sb.rs)
            n_restarts++;
        burst_left--;
    endtask

    // Drain results and let the sequencer finish before touching registers
    task automatic drain_idle();
        in_valid <= 1'b0;
        burst_left = 0;
        while (pending_rows.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    task automatic write_regs(input logic [31:0] vals[7]);
        for (int i = 0; i < 7; i++)
        begin
            cfg_we <= 1'b1;
            cfg_index <= 3'(i);
            cfg_data <= vals[i];
            @(posedge clk);
        end
        cfg_front = vals[REG_FRONT][15:0];
        cfg_rear = vals[REG_REAR][15:0];
        cfg_dt = vals[REG_DT][15:0];
        cfg_x0 = vals[REG_INIT_X];
        cfg_y0 = vals[REG_INIT_Y];
        cfg_v0 = vals[REG_INIT_V][15:0];
        cfg_hd0 = vals[REG_INIT_HD][15:0];
        // unused index: must be ignored
        cfg_index <= 3'd7;
        cfg_data <= $urandom;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    function automatic stim_t rand_beat();
        stim_t sb;
        sb.typed = 1'b0;
        sb.rs = ($urandom_range(99) < 4);
        sb.acc = 16'($urandom);
        if ($urandom_range(3) == 0)
            sb.st = 16'($urandom);
        else
            sb.st = 16'($signed($urandom_range(29126)) - 14563);
        return sb;
    endfunction

    initial
    begin
        stim_t         plan[PLAN_ROWS];
        stim_t         sb;
        row_t          zero_row;
        logic [31:0]   regs[7];
        logic [31:0]   phase_regs[PHASES][7];

        rst_n = 1'b0;
        in_valid = 1'b0;
        restart = 1'b0;
        acceleration = '0;
        steer_angle = '0;
        out_stall = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        n_fail = 0;
        n_beats = 0;
        n_rows = 0;
        n_restarts = 0;
        burst_left = 0;
        gap_max = 3;
        stall_pct = 30;
        cfg_front = RST_FRONT;
        cfg_rear = RST_REAR;
        cfg_dt = RST_DT;
        cfg_x0 = '0;
        cfg_y0 = '0;
        cfg_v0 = '0;
        cfg_hd0 = '0;
        veh_x = '0;
        veh_y = '0;
        veh_v = '0;
        veh_hd = '0;
        veh_ticks = '0;
        zero_row = '{idx: 0, x: 0, y: 0, v: 0, hd: 0};

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset state, acceleration and steer extremes, steer clamp, restart
        plan[0]  = '{rs: 0, acc: 0, st: 0, typed: 1, row: zero_row};
        plan[1]  = '{rs: 1, acc: 0, st: 0, typed: 1, row: zero_row};
        plan[2]  = '{rs: 0, acc: 16'sh7FFF, st: 16'sh7FFF, typed: 0, row: zero_row};
        plan[3]  = '{rs: 0, acc: 16'sh7FFF, st: 16'sh8000, typed: 0, row: zero_row};
        plan[4]  = '{rs: 0, acc: 16'sh7FFF, st: 16'sd14563, typed: 0, row: zero_row};
        plan[5]  = '{rs: 0, acc: 16'sh7FFF, st: -16'sd14563, typed: 0, row: zero_row};
        plan[6]  = '{rs: 0, acc: 16'sh0100, st: 16'sd14564, typed: 0, row: zero_row};
        plan[7]  = '{rs: 0, acc: 16'sh8000, st: 16'sd0, typed: 0, row: zero_row};
        plan[8]  = '{rs: 0, acc: 16'sh8000, st: -16'sd1, typed: 0, row: zero_row};
        plan[9]  = '{rs: 0, acc: 16'sh8000, st: 16'sd1, typed: 0, row: zero_row};
        plan[10] = '{rs: 0, acc: 16'shFFFF, st: 16'sd8192, typed: 0, row: zero_row};
        plan[11] = '{rs: 0, acc: 16'sh5555, st: 16'shAAAA, typed: 0, row: zero_row};
        plan[12] = '{rs: 0, acc: 16'shAAAA, st: 16'sh5555, typed: 0, row: zero_row};
        plan[13] = '{rs: 1, acc: 16'sh7FFF, st: 16'sh7FFF, typed: 1, row: zero_row};
        plan[14] = '{rs: 0, acc: 16'sh7FFF, st: 16'sd4000, typed: 0, row: zero_row};
        foreach (plan[i])
            send_beat(plan[i]);

        // Register settings per phase: defaults first, then the extremes
        phase_regs[0] = '{384, 384, 6554, 0, 0, 0, 0};
        phase_regs[1] = '{1, 1, 65535, 32'h7FFF_0000, 32'h8000_0000, 16'h7FFF, 0};
        phase_regs[2] = '{65535, 65535, 1, 32'h8000_0000, 32'h7FFF_FFFF, 16'h8000, 16'hFFFF};
        phase_regs[3] = '{384, 0, 6554, 32'h0001_0000, 0, 16'h0A00, 16'h4000};
        phase_regs[4] = '{0, 0, 20000, 0, 32'hFFFF_0000, 16'h0500, 16'hC000};
        phase_regs[5] = '{384, 384, 0, 32'h1234_5678, 32'h8765_4321, 16'h7FFF, 16'h8000};
        phase_regs[6] = '{1, 65535, 65535, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h7FFF, 16'h2000};
        phase_regs[7] = '{65535, 1, 65535, 32'h8000_0000, 32'h8000_0000, 16'h8000, 16'hE000};
        phase_regs[8] = '{0, 500, 30000, 0, 0, 16'hFF00, 16'hFFFF};
        phase_regs[9] = '{$urandom_range(1, 65535), $urandom_range(1, 65535),
                          $urandom_range(1, 65535), $urandom, $urandom,
                          $urandom_range(65535), $urandom_range(65535)};

        for (int p = 0; p < PHASES; p++)
        begin
            drain_idle();
            regs = phase_regs[p];
            write_regs(regs);
            // vary idling: some phases run without gaps or stalls
            gap_max = (p % 3 == 0) ? 0 : $urandom_range(1, 20);
            stall_pct = (p % 4 == 1) ? 0 : $urandom_range(10, 80);
            sb = '{rs: 1, acc: 0, st: 0, typed: 0, row: zero_row};
            send_beat(sb);
            for (int k = 0; k < PHASE_BEATS; k++)
            begin
                if (k == PHASE_BEATS / 2)
                begin
                    in_valid <= 1'b0;
                    burst_left = 0;
                    while (pending_rows.size() != 0)
                        @(posedge clk);
                end
                send_beat(rand_beat());
            end
        end

        // Wind down
        in_valid <= 1'b0;
        while (pending_rows.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);

        $display("Covered %0d input beats (%0d restarts), %0d result rows over %0d settings.",
                 n_beats, n_restarts, n_rows, PHASES + 1);
        if (n_fail == 0)
            $display("[kinematic_bicycle_step] OK");
        else
            $display("[kinematic_bicycle_step] ERROR");
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/kbs_pkg.sv
hdl/kinematic_bicycle_step.sv
tb/kinematic_bicycle_step_test.sv
